/* hdl/wrm_pkg.sv */
// Shared constants and types for the windowed rate meter.
`default_nettype none
package wrm_pkg;
   localparam int RING_DEPTH = 4096;
   localparam int CHANNELS   = 8;
   localparam int PTR_W      = $clog2(RING_DEPTH);
   localparam int CH_W       = 3;
   localparam int CHI_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int MEM_DEPTH  = CHANNELS * RING_DEPTH;
   localparam int ADDR_W     = $clog2(MEM_DEPTH);
   localparam logic [63:0] RATE_SCALE = 64'd65536000;

   typedef enum logic [0:0] {
      OP_PUSH  = 1'b0,
      OP_QUERY = 1'b1
   } opcode_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_WAIT,
      ST_CHECK,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_MUL_SUM,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_OUT
   } state_type;

   // Request and status between the sequencer and the divider.
   typedef struct packed {
      logic        start;
      logic [63:0] num_hi;
      logic [63:0] num_lo;
      logic [63:0] den;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [63:0] quo;
   } div_rsp_type;
endpackage
`default_nettype wire

/* hdl/wrm_ring_mem.sv */
// Sample ring storage: one (count, stamp) pair per entry, registered read.
`default_nettype none
module wrm_ring_mem (
   input  wire logic                      clock,
   input  wire logic                      wr_en,
   input  wire logic [wrm_pkg::ADDR_W-1:0] wr_addr,
   input  wire logic [127:0]              wr_data,
   input  wire logic [wrm_pkg::ADDR_W-1:0] rd_addr,
   output logic      [127:0]              rd_data
);
   logic [127:0] mem [wrm_pkg::MEM_DEPTH];

   // Write one entry, read one entry per cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

/* hdl/wrm_divider.sv */
// Restoring divider: 128-bit numerator by 64-bit denominator, one bit per cycle.
`default_nettype none
module wrm_divider (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire wrm_pkg::div_req_type req,
   output wrm_pkg::div_rsp_type      rsp
);
   logic        busy_ff, busy_in;
   logic [6:0]  bit_ff, bit_in;
   logic [63:0] rem_ff, rem_in;
   logic [63:0] lo_ff, lo_in;
   logic [63:0] den_ff, den_in;
   logic [63:0] quo_ff, quo_in;
   logic        done_ff, done_in;
   logic [64:0] shifted;

   // Shift one numerator bit in, subtract when it fits.
   always_comb begin
      busy_in = busy_ff;
      bit_in  = bit_ff;
      rem_in  = rem_ff;
      lo_in   = lo_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      done_in = 1'b0;
      shifted = {rem_ff, lo_ff[63]};
      if (req.start) begin
         busy_in = 1'b1;
         bit_in  = 7'd0;
         rem_in  = req.num_hi;
         lo_in   = req.num_lo;
         den_in  = req.den;
         quo_in  = '0;
      end else if (busy_ff) begin
         lo_in = {lo_ff[62:0], 1'b0};
         if (shifted >= {1'b0, den_ff}) begin
            rem_in = 64'(shifted - {1'b0, den_ff});
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = shifted[63:0];
            quo_in = {quo_ff[62:0], 1'b0};
         end
         bit_in = bit_ff + 7'd1;
         if (bit_ff == 7'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      bit_ff <= bit_in;
      rem_ff <= rem_in;
      lo_ff  <= lo_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quo  = quo_ff;
endmodule
`default_nettype wire

/* hdl/windowed_rate_meter.sv */
// Top level of the windowed rate meter: sequencer, ring memory and divider.
//  channel | valid     | stall     | payload
//  req     | req_valid | req_stall | opcode, channel, running_count, sample_time_ms,
//          |           |           | now_ms, window_ms
//  rsp     | rsp_valid | rsp_stall | rate_valid, rate_q16
// A query walks up to RING_DEPTH-1 ring entries, one memory read each (READ,
// WAIT and CHECK per entry), then runs the multiply, the bit-serial 64-step
// divide when one is needed, and result staging.
// After reset a clearing pass writes every ring entry, CHANNELS*RING_DEPTH
// entries (32768), before the first word is taken.
// A stalled result holds in the output register; no new word is taken until
// it leaves.
`default_nettype none
module windowed_rate_meter (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [0:0]  req_opcode,
   input  wire logic [2:0]  req_channel,
   input  wire logic [63:0] req_running_count,
   input  wire logic [63:0] req_sample_time_ms,
   input  wire logic [63:0] req_now_ms,
   input  wire logic [31:0] req_window_ms,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_rate_valid,
   output logic [63:0]      rsp_rate_q16
);
   localparam int PW = wrm_pkg::PTR_W;
   localparam int AW = wrm_pkg::ADDR_W;

   wrm_pkg::state_type state_ff, state_in;
   logic [PW-1:0] top_ff [wrm_pkg::CHANNELS];
   logic [AW-1:0] clr_ff, clr_in;
   logic [wrm_pkg::CHI_W-1:0] ch_ff, ch_in;
   logic [PW-1:0] idx_ff, idx_in;   // steps walked
   logic [63:0] now_ff, now_in;
   logic [31:0] win_ff, win_in;
   logic [63:0] late_c_ff, late_c_in, late_s_ff, late_s_in;
   logic [63:0] early_c_ff, early_c_in, early_s_ff, early_s_in;
   logic        full_ff, full_in;
   logic [63:0] dcnt_ff, dcnt_in, dst_ff, dst_in;
   logic [63:0] plo_ff, plo_in, phi_ff, phi_in;
   logic [63:0] nhi_ff, nhi_in, nlo_ff, nlo_in;
   logic        ov_valid_ff, ov_valid_in;
   logic [63:0] ov_rate_ff, ov_rate_in;
   logic        ov_full_ff, ov_full_in;

   logic          mem_we;
   logic [AW-1:0] mem_wa, mem_ra;
   logic [127:0]  mem_wd, mem_rd;
   wrm_pkg::div_req_type dreq;
   wrm_pkg::div_rsp_type drsp;
   logic          req_take, ch_ok, top_we;
   logic [PW-1:0] cur_top, rd_slot;
   logic [63:0]   st, cn, age;

   wrm_ring_mem u_mem (
      .clock(clock), .wr_en(mem_we), .wr_addr(mem_wa), .wr_data(mem_wd),
      .rd_addr(mem_ra), .rd_data(mem_rd)
   );

   wrm_divider u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

   assign ch_ok    = 32'(req_channel) < wrm_pkg::CHANNELS;
   assign req_stall = (state_ff != wrm_pkg::ST_IDLE) || ov_full_ff;
   assign req_take  = req_valid && !req_stall;
   assign cur_top   = top_ff[ch_ff];
   assign rd_slot   = PW'(cur_top - idx_ff);
   assign st        = mem_rd[63:0];
   assign cn        = mem_rd[127:64];
   assign age       = now_ff - st;

   // Sequence the clearing pass, push, walk, multiply and divide.
   always_comb begin
      state_in    = state_ff;
      clr_in      = clr_ff;
      ch_in       = ch_ff;
      idx_in      = idx_ff;
      now_in      = now_ff;
      win_in      = win_ff;
      late_c_in   = late_c_ff;
      late_s_in   = late_s_ff;
      early_c_in  = early_c_ff;
      early_s_in  = early_s_ff;
      full_in     = full_ff;
      dcnt_in     = dcnt_ff;
      dst_in      = dst_ff;
      plo_in      = plo_ff;
      phi_in      = phi_ff;
      nhi_in      = nhi_ff;
      nlo_in      = nlo_ff;
      ov_valid_in = ov_valid_ff;
      ov_rate_in  = ov_rate_ff;
      ov_full_in  = ov_full_ff;
      mem_we      = 1'b0;
      mem_wa      = clr_ff;
      mem_wd      = '0;
      mem_ra      = {ch_ff, rd_slot};
      top_we      = 1'b0;
      dreq        = '0;
      dreq.num_hi = nhi_ff;
      dreq.num_lo = nlo_ff;
      dreq.den    = dst_ff;
      if (ov_full_ff && !rsp_stall) begin
         ov_full_in = 1'b0;
      end
      unique case (state_ff)
         wrm_pkg::ST_CLEAR: begin
            mem_we = 1'b1;
            clr_in = AW'(clr_ff + 1'b1);
            if (clr_ff == AW'(wrm_pkg::MEM_DEPTH - 1)) begin
               state_in = wrm_pkg::ST_IDLE;
            end
         end
         wrm_pkg::ST_IDLE: begin
            if (req_take) begin
               ch_in      = wrm_pkg::CHI_W'(req_channel);
               now_in     = req_now_ms;
               win_in     = req_window_ms;
               idx_in     = PW'(1);
               late_s_in  = '0;
               late_c_in  = '0;
               early_s_in = '0;
               early_c_in = '0;
               full_in    = 1'b0;
               if (req_opcode == wrm_pkg::OP_PUSH) begin
                  if (ch_ok) begin
                     mem_we = 1'b1;
                     mem_wa = {wrm_pkg::CHI_W'(req_channel),
                               top_ff[wrm_pkg::CHI_W'(req_channel)]};
                     mem_wd = {req_running_count, req_sample_time_ms};
                     top_we = 1'b1;
                  end
               end else if (ch_ok) begin
                  state_in = wrm_pkg::ST_READ;
               end else begin
                  ov_valid_in = 1'b0;
                  ov_rate_in  = '0;
                  ov_full_in  = 1'b1;
               end
            end
         end
         wrm_pkg::ST_READ: begin
            state_in = wrm_pkg::ST_WAIT;
         end
         wrm_pkg::ST_WAIT: begin
            state_in = wrm_pkg::ST_CHECK;
         end
         wrm_pkg::ST_CHECK: begin
            state_in = wrm_pkg::ST_READ;
            if (st == '0) begin
               state_in = wrm_pkg::ST_MUL_LO;
            end else begin
               if (late_s_ff == '0) begin
                  late_s_in = st;
                  late_c_in = cn;
               end
               if (age > {32'd0, win_ff}) begin
                  full_in  = 1'b1;
                  state_in = wrm_pkg::ST_MUL_LO;
               end else begin
                  early_s_in = st;
                  early_c_in = cn;
                  if (idx_ff == PW'(wrm_pkg::RING_DEPTH - 1)) begin
                     state_in = wrm_pkg::ST_MUL_LO;
                  end
                  idx_in = PW'(idx_ff + 1'b1);
               end
            end
            dcnt_in = late_c_in - early_c_in;
            dst_in  = late_s_in - early_s_in;
         end
         wrm_pkg::ST_MUL_LO: begin
            if (!full_ff || early_s_ff == '0 || late_s_ff == '0 ||
                late_s_ff == early_s_ff) begin
               ov_valid_in = 1'b0;
               ov_rate_in  = '0;
               ov_full_in  = 1'b1;
               state_in    = wrm_pkg::ST_OUT;
            end else begin
               plo_in   = {32'd0, dcnt_ff[31:0]} * wrm_pkg::RATE_SCALE;
               state_in = wrm_pkg::ST_MUL_HI;
            end
         end
         wrm_pkg::ST_MUL_HI: begin
            phi_in   = {32'd0, dcnt_ff[63:32]} * wrm_pkg::RATE_SCALE;
            state_in = wrm_pkg::ST_MUL_SUM;
         end
         wrm_pkg::ST_MUL_SUM: begin
            nlo_in   = plo_ff + {phi_ff[31:0], 32'd0};
            nhi_in   = {32'd0, phi_ff[63:32]} +
                       64'((plo_ff + {phi_ff[31:0], 32'd0}) < plo_ff);
            state_in = wrm_pkg::ST_DIV_START;
         end
         wrm_pkg::ST_DIV_START: begin
            if (nhi_ff >= dst_ff) begin
               ov_valid_in = 1'b1;
               ov_rate_in  = '1;
               ov_full_in  = 1'b1;
               state_in    = wrm_pkg::ST_OUT;
            end else begin
               dreq.start = 1'b1;
               state_in   = wrm_pkg::ST_DIV_WAIT;
            end
         end
         wrm_pkg::ST_DIV_WAIT: begin
            if (drsp.done) begin
               ov_valid_in = 1'b1;
               ov_rate_in  = drsp.quo;
               ov_full_in  = 1'b1;
               state_in    = wrm_pkg::ST_OUT;
            end
         end
         wrm_pkg::ST_OUT: begin
            state_in = wrm_pkg::ST_IDLE;
         end
         default: state_in = wrm_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= wrm_pkg::ST_CLEAR;
         clr_ff     <= '0;
         ov_full_ff <= 1'b0;
         for (int c = 0; c < wrm_pkg::CHANNELS; c++) begin
            top_ff[c] <= '0;
         end
      end else begin
         state_ff   <= state_in;
         clr_ff     <= clr_in;
         ov_full_ff <= ov_full_in;
         if (top_we) begin
            top_ff[wrm_pkg::CHI_W'(req_channel)] <=
               PW'(top_ff[wrm_pkg::CHI_W'(req_channel)] + 1'b1);
         end
      end
      ch_ff       <= ch_in;
      idx_ff      <= idx_in;
      now_ff      <= now_in;
      win_ff      <= win_in;
      late_c_ff   <= late_c_in;
      late_s_ff   <= late_s_in;
      early_c_ff  <= early_c_in;
      early_s_ff  <= early_s_in;
      full_ff     <= full_in;
      dcnt_ff     <= dcnt_in;
      dst_ff      <= dst_in;
      plo_ff      <= plo_in;
      phi_ff      <= phi_in;
      nhi_ff      <= nhi_in;
      nlo_ff      <= nlo_in;
      ov_valid_ff <= ov_valid_in;
      ov_rate_ff  <= ov_rate_in;
   end

   assign rsp_valid      = ov_full_ff;
   assign rsp_rate_valid = ov_valid_ff;
   assign rsp_rate_q16   = ov_rate_ff;
endmodule
`default_nettype wire

/* hdl/wrm_checker.sv */
// Port-level checks for the windowed rate meter, bound to the top level.
`default_nettype none
module wrm_assertions (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic        rsp_rate_valid,
   input wire logic [63:0] rsp_rate_q16
);
   // An invalid rate reads zero.
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_rate_valid |-> rsp_rate_q16 == '0)
      else $error("invalid rate not zero");

   // A pending word blocks new requests.
   a_busy_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request taken while result pending");

   // A stalled word holds.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_rate_q16))
      else $error("stalled result changed");

   // A request is never taken while a result word is shown.
   a_take_idle: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |-> !rsp_valid)
      else $error("request taken beside a result word");

   // Reset clears the result channel.
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("output after reset");
endmodule

bind windowed_rate_meter wrm_assertions u_wrm_assertions (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
   .rsp_rate_valid(rsp_rate_valid), .rsp_rate_q16(rsp_rate_q16)
);
`default_nettype wire

/* dv/wrm_checker.sv */
// Checker for the windowed rate meter: watches both channels, predicts rates, compares.
`timescale 1ns / 100ps
`default_nettype none
module wrm_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_stall,
   input  wire logic [0:0]  req_opcode,
   input  wire logic [2:0]  req_channel,
   input  wire logic [63:0] req_running_count,
   input  wire logic [63:0] req_sample_time_ms,
   input  wire logic [63:0] req_now_ms,
   input  wire logic [31:0] req_window_ms,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_stall,
   input  wire logic        rsp_rate_valid,
   input  wire logic [63:0] rsp_rate_q16,
   output int               fail_count,
   output int               rates_pending
);
   typedef struct packed {
      logic        ok;
      logic [63:0] rate;
   } rate_word_type;

   logic [63:0]               count_mem [wrm_pkg::CHANNELS][wrm_pkg::RING_DEPTH];
   logic [63:0]               stamp_mem [wrm_pkg::CHANNELS][wrm_pkg::RING_DEPTH];
   logic [wrm_pkg::PTR_W-1:0] head_ptr  [wrm_pkg::CHANNELS];
   rate_word_type             rates_due [$];

   assign rates_pending = rates_due.size();

   // Walk back from the newest sample and turn the window into a Q48.16 rate.
   function automatic rate_word_type estimate_rate(input logic [2:0] ch,
                                                   input logic [63:0] now,
                                                   input logic [31:0] win);
      rate_word_type             r;
      logic [63:0]               early_cnt, early_st, late_cnt, late_st, st;
      logic [wrm_pkg::PTR_W-1:0] idx;
      logic [127:0]              prod, quo;
      bit                        full;
      r = '0;
      early_cnt = '0; early_st = '0; late_cnt = '0; late_st = '0;
      full = 1'b0;
      if (ch >= wrm_pkg::CHANNELS) return r;
      for (int i = 1; i < wrm_pkg::RING_DEPTH; i++) begin
         idx = head_ptr[ch] - wrm_pkg::PTR_W'(i);
         st  = stamp_mem[ch][idx];
         if (st == 0) break;
         if (late_st == 0) begin
            late_st  = st;
            late_cnt = count_mem[ch][idx];
         end
         if (now - st > {32'b0, win}) begin
            full = 1'b1;
            break;
         end
         early_st  = st;
         early_cnt = count_mem[ch][idx];
      end
      if (!full || early_st == 0 || late_st == 0 || late_st == early_st) return r;
      prod = {64'b0, late_cnt - early_cnt} * {64'b0, wrm_pkg::RATE_SCALE};
      quo  = prod / {64'b0, late_st - early_st};
      r.ok   = 1'b1;
      r.rate = (quo[127:64] != 0) ? '1 : quo[63:0];
      return r;
   endfunction

   // Track ring contents, queue expected rates, check each result word.
   always @(posedge clock) begin
      rate_word_type want;
      if (reset) begin
         for (int c = 0; c < wrm_pkg::CHANNELS; c++) begin
            head_ptr[c] <= '0;
            for (int j = 0; j < wrm_pkg::RING_DEPTH; j++) begin
               count_mem[c][j] = '0;
               stamp_mem[c][j] = '0;
            end
         end
         rates_due.delete();
      end else begin
         if (req_valid && !req_stall) begin
            if (wrm_pkg::opcode_type'(req_opcode) == wrm_pkg::OP_PUSH) begin
               if (req_channel < wrm_pkg::CHANNELS) begin
                  count_mem[req_channel][head_ptr[req_channel]] = req_running_count;
                  stamp_mem[req_channel][head_ptr[req_channel]] = req_sample_time_ms;
                  head_ptr[req_channel] <= head_ptr[req_channel] + 1'b1;
               end
            end else begin
               rates_due = {rates_due,
                            estimate_rate(req_channel, req_now_ms, req_window_ms)};
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (rates_due.size() == 0) begin
               $error("unexpected result word: rate_valid=%0d rate_q16=%0h",
                      rsp_rate_valid, rsp_rate_q16);
               fail_count++;
            end else begin
               want = rates_due.pop_front();
               if (rsp_rate_valid !== want.ok) begin
                  $error("rate_valid: expected %0d, got %0d", want.ok, rsp_rate_valid);
                  fail_count++;
               end
               if (rsp_rate_q16 !== want.rate) begin
                  $error("rate_q16: expected %0h, got %0h", want.rate, rsp_rate_q16);
                  fail_count++;
               end
            end
         end
      end
   end
endmodule
`default_nettype wire

/* dv/tb.sv */
// Testbench top for the windowed rate meter: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
`default_nettype none
module tb;
   localparam int RANDOM_WORDS = 120;
   localparam int STALL_LIMIT  = 150000;
   localparam int DRAIN_CYCLES = 200;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [0:0]  req_opcode = wrm_pkg::OP_PUSH;
   logic [2:0]  req_channel = '0;
   logic [63:0] req_running_count = '0;
   logic [63:0] req_sample_time_ms = '0;
   logic [63:0] req_now_ms = '0;
   logic [31:0] req_window_ms = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_rate_valid;
   logic [63:0] rsp_rate_q16;
   int          fail_count, rates_pending;
   int          tx_idle_pct = 37, rx_idle_pct = 71;
   int          quiet_cycles = 0;
   logic [63:0] last_stamp [wrm_pkg::CHANNELS];
   logic [63:0] last_count [wrm_pkg::CHANNELS];

   windowed_rate_meter dut (.*);

   wrm_checker chk (.*);

   always #5 clock = ~clock;

   // Receiver backpressure.
   always @(posedge clock) rsp_stall <= ($urandom_range(99) < rx_idle_pct);

   // Watchdog on cycles with no word moving on either channel.
   always @(posedge clock) begin
      if (!reset && ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)))
         quiet_cycles <= 0;
      else if (!reset)
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Present one word, idling first at random, and hold it until taken.
   task automatic send_word(input wrm_pkg::opcode_type op, input logic [2:0] ch,
                            input logic [63:0] cnt, input logic [63:0] st,
                            input logic [63:0] now, input logic [31:0] win);
      if ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < tx_idle_pct) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_opcode         <= op;
      req_channel        <= ch;
      req_running_count  <= cnt;
      req_sample_time_ms <= st;
      req_now_ms         <= now;
      req_window_ms      <= win;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic push_sample(input logic [2:0] ch, input logic [63:0] cnt,
                              input logic [63:0] st);
      send_word(wrm_pkg::OP_PUSH, ch, cnt, st, {$urandom, $urandom}, $urandom);
   endtask

   task automatic query_rate(input logic [2:0] ch, input logic [63:0] now,
                             input logic [31:0] win);
      send_word(wrm_pkg::OP_QUERY, ch, {$urandom, $urandom}, {$urandom, $urandom},
                now, win);
   endtask

   // One random word: mostly well-formed per-channel histories, some noise.
   task automatic random_word();
      logic [2:0]  ch;
      int unsigned pick;
      ch   = 3'($urandom_range(wrm_pkg::CHANNELS - 1));
      pick = $urandom_range(99);
      if (pick < 10) begin
         send_word(wrm_pkg::opcode_type'($urandom_range(1)), ch, {$urandom, $urandom},
                   {$urandom, $urandom}, {$urandom, $urandom}, $urandom);
      end else if (pick < 60) begin
         last_stamp[ch] += $urandom_range(1, 400);
         last_count[ch] += ($urandom_range(9) == 0) ? {$urandom, $urandom}
                                                    : 64'($urandom_range(5000));
         push_sample(ch, last_count[ch], last_stamp[ch]);
      end else begin
         query_rate(ch, last_stamp[ch] + $urandom_range(300),
                    ($urandom_range(19) == 0) ? $urandom : $urandom_range(1500));
      end
   endtask

   initial begin
      for (int c = 0; c < wrm_pkg::CHANNELS; c++) begin
         last_stamp[c] = ($urandom_range(1) != 0) ? {$urandom, $urandom} : 64'd5000;
         last_count[c] = {$urandom, $urandom};
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty ring, one sample, zero elapsed, partial set, a clean rate.
      query_rate(3'd0, 64'd100, 32'd50);
      push_sample(3'd1, 64'd100, 64'd1000);
      query_rate(3'd1, 64'd1000, 32'd0);
      push_sample(3'd1, 64'd600, 64'd2000);
      query_rate(3'd1, 64'd2000, 32'd500);
      query_rate(3'd1, 64'd2000, 32'd1500);
      push_sample(3'd1, 64'd1600, 64'd3000);
      query_rate(3'd1, 64'd3000, 32'd1500);
      // Now behind the stamps wraps to a huge age; widest window.
      query_rate(3'd1, 64'd0, '1);
      query_rate(3'd1, '1, '1);
      // Saturating rate: full count swing over one millisecond.
      push_sample(3'd2, 64'd0, 64'd1);
      push_sample(3'd2, 64'd0, 64'd10);
      push_sample(3'd2, '1, 64'd11);
      query_rate(3'd2, 64'd11, 32'd5);
      // A zero stamp reads back as an empty slot and cuts the walk.
      push_sample(3'd3, 64'd5, 64'd100);
      push_sample(3'd3, 64'd7, 64'd0);
      push_sample(3'd3, 64'd9, 64'd200);
      query_rate(3'd3, 64'd200, 32'd50);
      // All-ones fields on the top channel.
      push_sample(3'd7, 64'd0, 64'hFFFF_FFFF_FFFF_FFF0);
      push_sample(3'd7, '1, '1);
      query_rate(3'd7, '1, 32'd0);
      query_rate(3'd7, '1, 32'd14);

      // Hold off until every rate has come back.
      req_valid <= 1'b0;
      wait (rates_pending == 0);
      @(posedge clock);

      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if (n == 0) begin
            tx_idle_pct = 37; rx_idle_pct = 71;
         end else if (n == RANDOM_WORDS / 3) begin
            tx_idle_pct = 71; rx_idle_pct = 37;
         end else if (n == 2 * RANDOM_WORDS / 3) begin
            tx_idle_pct = 0;  rx_idle_pct = 0;
         end
         random_word();
      end
      req_valid <= 1'b0;

      // Drain outstanding rates, then give the block time to misbehave.
      wait (rates_pending == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule
`default_nettype wire
